/* rtl/wsfm_pkg.sv */
// Shared types, codes and limits for the window stack and focus manager.
package wsfm_pkg;

    // Slot count limits and the widest slot index the cell update carries
    localparam int SLOTS_DEF = 16;
    localparam int SLOTS_MAX = 64;
    localparam int IDX_W_MAX = $clog2(SLOTS_MAX);

    // Command kinds
    localparam logic [2:0] KIND_CREATE  = 3'd0;
    localparam logic [2:0] KIND_DESTROY = 3'd1;
    localparam logic [2:0] KIND_RAISE   = 3'd2;
    localparam logic [2:0] KIND_FOCUS   = 3'd3;
    localparam logic [2:0] KIND_LOOKUP  = 3'd4;

    // Result event codes
    localparam logic [1:0] EV_DONE   = 2'd0;
    localparam logic [1:0] EV_FAIL   = 2'd1;
    localparam logic [1:0] EV_LOST   = 2'd2;
    localparam logic [1:0] EV_GAINED = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] window_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] window_id_res;
        logic [3:0]  slot;
        logic [4:0]  stack_depth;
        logic        last;
    } res_t;

    // Parallel update broadcast to every cell of the ring
    typedef struct packed {
        logic                 en;
        logic                 ident_we;
        logic                 height_we;
        logic                 dec_en;
        logic [IDX_W_MAX-1:0] slot;
        logic [IDX_W_MAX-1:0] height;
        logic [IDX_W_MAX-1:0] dec_above;
        logic [31:0]          ident;
    } cell_upd_t;

endpackage

/* rtl/wsfm_cell.sv */
// One slot cell of the rotating ring: window id and stacking height.
module wsfm_cell
    import wsfm_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int CELL_IDX = 0
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  cell_upd_t                  upd,
    input  logic [31:0]                nb_ident,
    input  logic [$clog2(SLOTS)-1:0]   nb_height,
    output logic [31:0]                ident,
    output logic [$clog2(SLOTS)-1:0]   height
);

    localparam int HW = $clog2(SLOTS);

    logic [31:0]          ident_reg;
    logic [31:0]          ident_next;
    logic [HW-1:0]        height_reg;
    logic [HW-1:0]        height_next;
    logic [IDX_W_MAX-1:0] height_ext;
    logic                 self_hit;

    assign height_ext = IDX_W_MAX'(height_reg);
    assign self_hit   = (upd.slot == IDX_W_MAX'(CELL_IDX));

    // Take the neighbor's entry while rotating, else apply the broadcast update
    always_comb
    begin
        ident_next  = ident_reg;
        height_next = height_reg;
        if (shift)
        begin
            ident_next  = nb_ident;
            height_next = nb_height;
        end
        else if (upd.en)
        begin
            if (self_hit)
            begin
                if (upd.ident_we)
                begin
                    ident_next = upd.ident;
                end
                if (upd.height_we)
                begin
                    height_next = upd.height[HW-1:0];
                end
            end
            else if (upd.dec_en && (ident_reg != 32'd0) && (height_ext > upd.dec_above))
            begin
                height_next = height_reg - HW'(1);
            end
        end
    end

    // Hold the window id; zero marks a free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg <= '0;
        end
        else
        begin
            ident_reg <= ident_next;
        end
    end

    // Hold the stacking height; meaningful only while the slot is in use
    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
    end

    assign ident  = ident_reg;
    assign height = height_reg;

endmodule

/* rtl/wsfm_ctrl.sv */
// Head controller: scans the ring, decides the operation and emits results.
module wsfm_ctrl
    import wsfm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  cmd_t                       cmd,
    output logic                       busy,
    output res_t                       result,
    output logic                       result_strobe,
    output logic                       shift,
    output cell_upd_t                  upd,
    input  logic [31:0]                head_ident,
    input  logic [$clog2(SLOTS)-1:0]   head_height
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    function automatic logic [3:0] slot4(input logic [SW-1:0] s);
        logic [SW+3:0] e;
        e = {4'b0000, s};
        return e[3:0];
    endfunction

    function automatic res_t mk_item(input logic [1:0] ev, input logic [31:0] id,
                                     input logic [SW-1:0] s, input logic [CW-1:0] depth,
                                     input logic is_last);
        res_t r;
        logic [CW+4:0] d;
        d               = {5'b00000, depth};
        r.event_res     = ev;
        r.window_id_res = id;
        r.slot          = slot4(s);
        r.stack_depth   = d[4:0];
        r.last          = is_last;
        return r;
    endfunction

    // Control state
    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;
    logic          focus_valid_reg, focus_valid_next;
    logic [SW-1:0] focus_slot_reg, focus_slot_next;
    logic [31:0]   focus_id_reg, focus_id_next;
    logic [31:0]   next_id_reg, next_id_next;
    logic [1:0]    nitems_reg, nitems_next;
    logic          found_free_reg, found_free_next;
    logic          found_match_reg, found_match_next;

    // Transaction payload and scan captures
    logic [2:0]    kind_reg, kind_next;
    logic [31:0]   id_reg, id_next;
    logic [SW-1:0] free_slot_reg, free_slot_next;
    logic [SW-1:0] match_slot_reg, match_slot_next;
    logic [SW-1:0] match_h_reg, match_h_next;
    logic [SW-1:0] top_slot_reg, top_slot_next;
    logic [31:0]   top_id_reg, top_id_next;
    logic [SW-1:0] sec_slot_reg, sec_slot_next;
    logic [31:0]   sec_id_reg, sec_id_next;
    res_t          item_reg [3];
    res_t          item_next [3];

    // Evaluation terms
    logic          head_occ;
    logic [CW-1:0] head_h_ext;
    logic          lost_en;
    logic          gain_en;
    logic [31:0]   gain_id;
    logic [SW-1:0] gain_slot;
    logic [1:0]    fin_ev;
    logic [31:0]   fin_id;
    logic [SW-1:0] fin_slot;
    logic [CW-1:0] depth_new;
    logic [31:0]   id_inc;
    res_t          lost_item, gain_item, fin_item;

    assign head_occ   = (head_ident != 32'd0);
    assign head_h_ext = CW'(head_height);
    assign id_inc     = next_id_reg + 32'd1;

    // Decide the operation from the scan captures
    always_comb
    begin
        lost_en          = 1'b0;
        gain_en          = 1'b0;
        gain_id          = '0;
        gain_slot        = '0;
        fin_ev           = EV_FAIL;
        fin_id           = id_reg;
        fin_slot         = '0;
        depth_new        = count_reg;
        count_next       = count_reg;
        focus_valid_next = focus_valid_reg;
        focus_slot_next  = focus_slot_reg;
        focus_id_next    = focus_id_reg;
        next_id_next     = next_id_reg;
        upd              = '0;
        case (kind_reg)
            KIND_CREATE:
            begin
                fin_id = '0;
                if (found_free_reg)
                begin
                    upd.ident_we  = 1'b1;
                    upd.height_we = 1'b1;
                    upd.slot      = IDX_W_MAX'(free_slot_reg);
                    upd.ident     = next_id_reg;
                    upd.height    = IDX_W_MAX'(count_reg);
                    upd.en        = (state_reg == ST_EVAL);
                    depth_new     = count_reg + CW'(1);
                    count_next    = depth_new;
                    next_id_next  = (id_inc == 32'd0) ? 32'd1 : id_inc;
                    lost_en       = focus_valid_reg;
                    gain_en       = 1'b1;
                    gain_id       = next_id_reg;
                    gain_slot     = free_slot_reg;
                    fin_ev        = EV_DONE;
                    fin_id        = next_id_reg;
                    fin_slot      = free_slot_reg;
                    focus_valid_next = 1'b1;
                    focus_slot_next  = free_slot_reg;
                    focus_id_next    = next_id_reg;
                end
            end
            KIND_DESTROY:
            begin
                if (found_match_reg)
                begin
                    upd.ident_we  = 1'b1;
                    upd.dec_en    = 1'b1;
                    upd.slot      = IDX_W_MAX'(match_slot_reg);
                    upd.dec_above = IDX_W_MAX'(match_h_reg);
                    upd.en        = (state_reg == ST_EVAL);
                    depth_new     = count_reg - CW'(1);
                    count_next    = depth_new;
                    fin_ev        = EV_DONE;
                    fin_slot      = match_slot_reg;
                    if (focus_valid_reg && (focus_slot_reg == match_slot_reg))
                    begin
                        if (depth_new != '0)
                        begin
                            gain_en = 1'b1;
                            if (CW'(match_h_reg) == count_reg - CW'(1))
                            begin
                                gain_id   = sec_id_reg;
                                gain_slot = sec_slot_reg;
                            end
                            else
                            begin
                                gain_id   = top_id_reg;
                                gain_slot = top_slot_reg;
                            end
                            focus_slot_next = gain_slot;
                            focus_id_next   = gain_id;
                        end
                        else
                        begin
                            focus_valid_next = 1'b0;
                            focus_slot_next  = '0;
                        end
                    end
                end
            end
            KIND_RAISE:
            begin
                if (found_match_reg)
                begin
                    upd.height_we = 1'b1;
                    upd.dec_en    = 1'b1;
                    upd.slot      = IDX_W_MAX'(match_slot_reg);
                    upd.height    = IDX_W_MAX'(count_reg - CW'(1));
                    upd.dec_above = IDX_W_MAX'(match_h_reg);
                    upd.en        = (state_reg == ST_EVAL);
                    fin_ev        = EV_DONE;
                    fin_slot      = match_slot_reg;
                end
            end
            KIND_FOCUS:
            begin
                if (id_reg == 32'd0)
                begin
                    lost_en          = focus_valid_reg;
                    focus_valid_next = 1'b0;
                    focus_slot_next  = '0;
                    fin_ev           = EV_DONE;
                end
                else if (found_match_reg)
                begin
                    lost_en          = focus_valid_reg && (focus_slot_reg != match_slot_reg);
                    gain_en          = 1'b1;
                    gain_id          = id_reg;
                    gain_slot        = match_slot_reg;
                    focus_valid_next = 1'b1;
                    focus_slot_next  = match_slot_reg;
                    focus_id_next    = id_reg;
                    fin_ev           = EV_DONE;
                    fin_slot         = match_slot_reg;
                end
            end
            KIND_LOOKUP:
            begin
                if (found_match_reg)
                begin
                    fin_ev   = EV_DONE;
                    fin_slot = match_slot_reg;
                end
            end
            default:
            begin
                fin_ev = EV_FAIL;
            end
        endcase
    end

    // Assemble result items in order: lost, gained, final
    always_comb
    begin
        lost_item = mk_item(EV_LOST, focus_id_reg, focus_slot_reg, depth_new, 1'b0);
        gain_item = mk_item(EV_GAINED, gain_id, gain_slot, depth_new, 1'b0);
        fin_item  = mk_item(fin_ev, fin_id, fin_slot, depth_new, 1'b1);
        item_next[0] = item_reg[1];
        item_next[1] = item_reg[2];
        item_next[2] = item_reg[2];
        if (state_reg == ST_EVAL)
        begin
            item_next[1] = fin_item;
            item_next[2] = fin_item;
            case ({lost_en, gain_en})
                2'b00:
                begin
                    item_next[0] = fin_item;
                end
                2'b01:
                begin
                    item_next[0] = gain_item;
                end
                2'b10:
                begin
                    item_next[0] = lost_item;
                end
                default:
                begin
                    item_next[0] = lost_item;
                    item_next[1] = gain_item;
                end
            endcase
        end
    end

    // Sequence accept, scan, evaluate and emit
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        nitems_next      = nitems_reg;
        found_free_next  = found_free_reg;
        found_match_next = found_match_reg;
        kind_next        = kind_reg;
        id_next          = id_reg;
        free_slot_next   = free_slot_reg;
        match_slot_next  = match_slot_reg;
        match_h_next     = match_h_reg;
        top_slot_next    = top_slot_reg;
        top_id_next      = top_id_reg;
        sec_slot_next    = sec_slot_reg;
        sec_id_next      = sec_id_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next        = cmd.kind;
                    id_next          = cmd.window_id;
                    step_next        = '0;
                    found_free_next  = 1'b0;
                    found_match_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!found_free_reg && !head_occ)
                begin
                    found_free_next = 1'b1;
                    free_slot_next  = step_reg;
                end
                if (!found_match_reg && (id_reg != 32'd0) && (head_ident == id_reg))
                begin
                    found_match_next = 1'b1;
                    match_slot_next  = step_reg;
                    match_h_next     = head_height;
                end
                if (head_occ && (head_h_ext == count_reg - CW'(1)))
                begin
                    top_slot_next = step_reg;
                    top_id_next   = head_ident;
                end
                if (head_occ && (head_h_ext == count_reg - CW'(2)))
                begin
                    sec_slot_next = step_reg;
                    sec_id_next   = head_ident;
                end
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(SLOTS - 1))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                nitems_next = 2'd1 + {1'b0, lost_en} + {1'b0, gain_en};
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                nitems_next = nitems_reg - 2'd1;
                if (nitems_reg == 2'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            nitems_reg      <= '0;
            found_free_reg  <= 1'b0;
            found_match_reg <= 1'b0;
            count_reg       <= '0;
            focus_valid_reg <= 1'b0;
            focus_slot_reg  <= '0;
            focus_id_reg    <= '0;
            next_id_reg     <= 32'd1;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            nitems_reg      <= nitems_next;
            found_free_reg  <= found_free_next;
            found_match_reg <= found_match_next;
            if (state_reg == ST_EVAL)
            begin
                count_reg       <= count_next;
                focus_valid_reg <= focus_valid_next;
                focus_slot_reg  <= focus_slot_next;
                focus_id_reg    <= focus_id_next;
                next_id_reg     <= next_id_next;
            end
        end
    end

    // Hold transaction payload, scan captures and pending results
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        free_slot_reg  <= free_slot_next;
        match_slot_reg <= match_slot_next;
        match_h_reg    <= match_h_next;
        top_slot_reg   <= top_slot_next;
        top_id_reg     <= top_id_next;
        sec_slot_reg   <= sec_slot_next;
        sec_id_reg     <= sec_id_next;
        item_reg[0]    <= item_next[0];
        item_reg[1]    <= item_next[1];
        item_reg[2]    <= item_next[2];
    end

    assign busy          = (state_reg != ST_IDLE);
    assign shift         = (state_reg == ST_SCAN);
    assign result        = item_reg[0];
    assign result_strobe = (state_reg == ST_EMIT);

endmodule

/* rtl/window_stack_and_focus_manager.sv */
// Top level: ring of slot cells around the head controller.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+---------------------
//  command   | start, busy (take: start&!busy) | cmd    (cmd_t)
//  result    | result_strobe, one cycle each | result (res_t)
//
// One command runs from acceptance to the next acceptance through a ring
// scan, one update and its results, n being its 1 to 3 results.
// The order is set by the ring: every slot rotates once past the head
// cell, one slot per cycle, then one update is applied to all cells.
// Reset frees every slot, clears focus and restarts ids at one.
// Results cannot be held off; busy stays high until the last one is out.
module window_stack_and_focus_manager
    import wsfm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output res_t result,
    output logic result_strobe
);

    localparam int SW = $clog2(SLOTS);

    logic          shift;
    cell_upd_t     upd;
    logic [31:0]   ident_w  [SLOTS];
    logic [SW-1:0] height_w [SLOTS];

    // Build the ring: each cell takes its upper neighbor, the last wraps to the head
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        wsfm_cell #(
            .SLOTS    (SLOTS),
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift),
            .upd       (upd),
            .nb_ident  (ident_w[(i + 1) % SLOTS]),
            .nb_height (height_w[(i + 1) % SLOTS]),
            .ident     (ident_w[i]),
            .height    (height_w[i])
        );
    end

    // Drive scan, decision and results from the head cell
    wsfm_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .busy          (busy),
        .result        (result),
        .result_strobe (result_strobe),
        .shift         (shift),
        .upd           (upd),
        .head_ident    (ident_w[0]),
        .head_height   (height_w[0])
    );

    // Results only appear inside a busy transaction
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe outside a transaction");

    // An accepted command makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start work");

    // The last result frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=> !busy)
        else $error("block still busy after last result");

    // A result that is not the last is followed at once by another
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |=> result_strobe)
        else $error("result burst broken before last item");

    // No cell update while the ring rotates
    a_no_upd_shift: assert property (@(posedge clk) disable iff (!rst_n)
        shift |-> !upd.en)
        else $error("cell update during rotation");

endmodule
